### src/riffcp_pkg.sv
// riffcp_pkg: shared types, constants and command codes for the RIFF chunk parser.
// Used by riffcp_ctrl, riffcp_dp and riff_chunk_parser_top; depends on nothing.
package riffcp_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int IDX_W     = $clog2(MAX_DEPTH);
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] MAX_SIZE = 32'hFFFF_FFF6;

  // parse phase
  localparam logic [2:0] PH_ID      = 3'd0;
  localparam logic [2:0] PH_SIZE    = 3'd1;
  localparam logic [2:0] PH_FORM    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_PAD     = 3'd4;
  localparam logic [2:0] PH_ERR     = 3'd5;

  // byte roles
  localparam logic [2:0] ROLE_ID      = 3'd0;
  localparam logic [2:0] ROLE_SIZE    = 3'd1;
  localparam logic [2:0] ROLE_FORM    = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
  localparam logic [2:0] ROLE_PAD     = 3'd4;
  localparam logic [2:0] ROLE_IGNORED = 3'd5;

  // chunk kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_RIFF  = 2'd1;
  localparam logic [1:0] KIND_LIST  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_RIFF_NEST = 3'd1;
  localparam logic [2:0] ERR_LIST_ROOT = 3'd2;
  localparam logic [2:0] ERR_PLAIN_ROOT = 3'd3;
  localparam logic [2:0] ERR_SMALL     = 3'd4;
  localparam logic [2:0] ERR_FIT       = 3'd5;
  localparam logic [2:0] ERR_PAD       = 3'd6;
  localparam logic [2:0] ERR_DEEP      = 3'd7;

  // datapath operations; also used as the "what comes next" status
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_ACCEPT = 3'd1;
  localparam logic [2:0] OP_DECODE = 3'd2;
  localparam logic [2:0] OP_FIN    = 3'd3;
  localparam logic [2:0] OP_CLOSE  = 3'd4;
  localparam logic [2:0] OP_POP    = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
  } req_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [4:0]  depth;
    logic [1:0]  chunk_kind;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_length;
    logic        header_done;
    logic [4:0]  levels_closed;
    logic        file_done;
    logic [2:0]  error_code;
  } rsp_t;

  typedef struct packed {
    logic [2:0] op;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] follow;
    logic       out_free;
  } status_t;

endpackage

### src/riffcp_ctrl.sv
// riffcp_ctrl: RIFF parser sequencer; issues one datapath op per cycle while working.
// Depends on riffcp_pkg.
module riffcp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  riffcp_pkg::status_t status,
  output riffcp_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state, state_next;
  logic [2:0] op, op_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd.op     = riffcp_pkg::OP_NONE;
    cmd.emit   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = riffcp_pkg::OP_ACCEPT;
          op_next    = riffcp_pkg::OP_DECODE;
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        cmd.op = op;
        if (status.follow == riffcp_pkg::OP_NONE) begin
          if (status.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_EMIT;
          end
        end else begin
          op_next = status.follow;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= riffcp_pkg::OP_NONE;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

endmodule

### src/riffcp_dp.sv
// riffcp_dp: header shift registers, level stack, per-byte result and output register.
// Depends on riffcp_pkg; driven by riffcp_ctrl.
module riffcp_dp (
  input  logic                clk,
  input  logic                rst,
  input  riffcp_pkg::req_t    req,
  input  riffcp_pkg::cmd_t    cmd,
  output riffcp_pkg::status_t status,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output riffcp_pkg::rsp_t    rsp
);

  localparam int IW = riffcp_pkg::IDX_W;
  localparam int CW = riffcp_pkg::CNT_W;

  logic [2:0]    phase, phase_next;
  logic [3:0]    hc, hc_next;
  logic [31:0]   tag, tag_next;
  logic [31:0]   len, len_next;
  logic [1:0]    kind, kind_next;
  logic [CW-1:0] lcount, lcount_next;
  logic [2:0]    err, err_next;
  logic [7:0]    b, b_next;
  logic [31:0]   tt, tt_next;
  logic          hs12, hs12_next;
  logic [2:0]    role, role_next;
  logic          hdr, hdr_next;
  logic [4:0]    closed, closed_next;
  logic          fdone, fdone_next;

  logic [31:0] ltot  [riffcp_pkg::MAX_DEPTH];
  logic [31:0] lleft [riffcp_pkg::MAX_DEPTH];

  logic          wr_tot_en, wr_left_en;
  logic [IW-1:0] wr_idx;
  logic [31:0]   wr_tot, wr_left;

  logic [IW-1:0] top;
  logic [31:0]   cur_left, cur_tot, nl, hsize, tot8;
  logic [32:0]   need;
  logic          empty, cnt_zero;
  logic [2:0]    follow;
  riffcp_pkg::rsp_t res_next;

  assign top      = lcount[IW-1:0] - IW'(1);
  assign cur_left = lleft[top];
  assign cur_tot  = ltot[top];
  assign cnt_zero = (lcount == '0);
  assign hsize    = hs12 ? 32'd12 : 32'd8;
  assign tot8     = len + 32'd8;
  assign need     = {1'b0, len} + 33'd8 + {32'd0, len[0]};
  assign empty    = (kind != riffcp_pkg::KIND_PLAIN) ? (len == 32'd4) : (len == 32'd0);

  always_comb begin
    phase_next  = phase;   hc_next     = hc;     tag_next    = tag;
    len_next    = len;     kind_next   = kind;   lcount_next = lcount;
    err_next    = err;     b_next      = b;      tt_next     = tt;
    hs12_next   = hs12;    role_next   = role;   hdr_next    = hdr;
    closed_next = closed;  fdone_next  = fdone;
    wr_tot_en   = 1'b0;    wr_left_en  = 1'b0;   wr_idx      = top;
    wr_tot      = cur_tot; wr_left     = cur_left;
    nl          = cur_left;
    follow      = riffcp_pkg::OP_NONE;
    case (cmd.op)
      riffcp_pkg::OP_ACCEPT: begin
        b_next      = req.in_byte;
        role_next   = riffcp_pkg::ROLE_IGNORED;
        hdr_next    = 1'b0;
        closed_next = '0;
        fdone_next  = 1'b0;
        if (req.start_of_file) begin
          phase_next  = riffcp_pkg::PH_ID;
          hc_next     = '0;
          tag_next    = '0;
          len_next    = '0;
          kind_next   = riffcp_pkg::KIND_PLAIN;
          lcount_next = '0;
          err_next    = riffcp_pkg::ERR_NONE;
        end
      end
      riffcp_pkg::OP_DECODE: begin
        hc_next = hc + 4'd1;
        case (phase)
          riffcp_pkg::PH_ID: begin
            role_next = riffcp_pkg::ROLE_ID;
            tag_next  = {b, tag[31:8]};
            if (hc_next >= 4'd4) phase_next = riffcp_pkg::PH_SIZE;
          end
          riffcp_pkg::PH_SIZE: begin
            role_next = riffcp_pkg::ROLE_SIZE;
            len_next  = {b, len[31:8]};
            if (hc_next >= 4'd8) begin
              kind_next = (tag == riffcp_pkg::TAG_RIFF) ? riffcp_pkg::KIND_RIFF :
                          (tag == riffcp_pkg::TAG_LIST) ? riffcp_pkg::KIND_LIST :
                                                          riffcp_pkg::KIND_PLAIN;
              if (kind_next == riffcp_pkg::KIND_RIFF && !cnt_zero) begin
                err_next = riffcp_pkg::ERR_RIFF_NEST; phase_next = riffcp_pkg::PH_ERR;
              end else if (kind_next == riffcp_pkg::KIND_LIST && cnt_zero) begin
                err_next = riffcp_pkg::ERR_LIST_ROOT; phase_next = riffcp_pkg::PH_ERR;
              end else if (kind_next == riffcp_pkg::KIND_PLAIN && cnt_zero) begin
                err_next = riffcp_pkg::ERR_PLAIN_ROOT; phase_next = riffcp_pkg::PH_ERR;
              end else if (kind_next != riffcp_pkg::KIND_PLAIN && len_next < 32'd4) begin
                err_next = riffcp_pkg::ERR_SMALL; phase_next = riffcp_pkg::PH_ERR;
              end else if (kind_next != riffcp_pkg::KIND_PLAIN) begin
                phase_next = riffcp_pkg::PH_FORM;
              end else begin
                hs12_next = 1'b0;
                follow    = riffcp_pkg::OP_FIN;
              end
            end
          end
          riffcp_pkg::PH_FORM: begin
            role_next = riffcp_pkg::ROLE_FORM;
            tag_next  = {b, tag[31:8]};
            if (hc_next >= 4'd12) begin
              hs12_next = 1'b1;
              follow    = riffcp_pkg::OP_FIN;
            end
          end
          riffcp_pkg::PH_PAYLOAD: begin
            role_next = riffcp_pkg::ROLE_PAYLOAD;
            hc_next   = hc;
            if (cnt_zero) begin
              phase_next = riffcp_pkg::PH_ID;
              hc_next    = '0;
            end else begin
              nl         = cur_left - 32'd1;
              wr_left_en = 1'b1;
              wr_left    = nl;
              if (nl == 32'd0) follow = riffcp_pkg::OP_CLOSE;
            end
          end
          riffcp_pkg::PH_PAD: begin
            role_next = riffcp_pkg::ROLE_PAD;
            hc_next   = hc;
            if (b != 8'd0) begin
              err_next = riffcp_pkg::ERR_PAD; phase_next = riffcp_pkg::PH_ERR;
            end else if (cnt_zero) begin
              phase_next = riffcp_pkg::PH_ID;
              hc_next    = '0;
            end else begin
              wr_tot_en = 1'b1;
              wr_tot    = cur_tot + 32'd1;
              follow    = riffcp_pkg::OP_CLOSE;
            end
          end
          default: begin
            role_next = riffcp_pkg::ROLE_IGNORED;
            hc_next   = hc;
          end
        endcase
      end
      riffcp_pkg::OP_FIN: begin
        hdr_next = 1'b1;
        hc_next  = '0;
        if (!empty) begin
          if (len > riffcp_pkg::MAX_SIZE) begin
            err_next = riffcp_pkg::ERR_FIT; phase_next = riffcp_pkg::PH_ERR;
          end else if (!cnt_zero && {1'b0, cur_left} < need) begin
            err_next = riffcp_pkg::ERR_FIT; phase_next = riffcp_pkg::PH_ERR;
          end else if (lcount >= CW'(riffcp_pkg::MAX_DEPTH)) begin
            err_next = riffcp_pkg::ERR_DEEP; phase_next = riffcp_pkg::PH_ERR;
          end else begin
            wr_idx      = lcount[IW-1:0];
            wr_tot_en   = 1'b1;
            wr_tot      = tot8;
            wr_left_en  = 1'b1;
            wr_left     = tot8 - hsize;
            lcount_next = lcount + CW'(1);
            phase_next  = (kind == riffcp_pkg::KIND_PLAIN) ? riffcp_pkg::PH_PAYLOAD
                                                           : riffcp_pkg::PH_ID;
          end
        end else if (!cnt_zero) begin
          if (cur_left < hsize) begin
            err_next = riffcp_pkg::ERR_FIT; phase_next = riffcp_pkg::PH_ERR;
          end else begin
            nl         = cur_left - hsize;
            wr_left_en = 1'b1;
            wr_left    = nl;
            phase_next = riffcp_pkg::PH_ID;
            if (nl == 32'd0) follow = riffcp_pkg::OP_CLOSE;
          end
        end else begin
          fdone_next = 1'b1;
          phase_next = riffcp_pkg::PH_ID;
        end
      end
      riffcp_pkg::OP_CLOSE: begin
        if (cnt_zero || cur_left != 32'd0) begin
          phase_next = riffcp_pkg::PH_ID;
          hc_next    = '0;
        end else if (cur_tot[0]) begin
          phase_next = riffcp_pkg::PH_PAD;
        end else begin
          // pop this level; the parent is charged for it in the next cycle
          tt_next     = cur_tot;
          lcount_next = lcount - CW'(1);
          closed_next = closed + 5'd1;
          if (lcount == CW'(1)) begin
            fdone_next = 1'b1;
            phase_next = riffcp_pkg::PH_ID;
            hc_next    = '0;
          end else begin
            follow = riffcp_pkg::OP_POP;
          end
        end
      end
      riffcp_pkg::OP_POP: begin
        wr_left_en = 1'b1;
        wr_left    = cur_left - tt;
        follow     = riffcp_pkg::OP_CLOSE;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_next.byte_role     = role_next;
    res_next.depth         = 5'(lcount_next);
    res_next.chunk_kind    = kind_next;
    res_next.chunk_tag     = tag_next;
    res_next.chunk_length  = len_next;
    res_next.header_done   = hdr_next;
    res_next.levels_closed = closed_next;
    res_next.file_done     = fdone_next;
    res_next.error_code    = err_next;
  end

  assign status.follow   = follow;
  assign status.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= riffcp_pkg::PH_ID;
      hc     <= '0;
      tag    <= '0;
      len    <= '0;
      kind   <= riffcp_pkg::KIND_PLAIN;
      lcount <= '0;
      err    <= riffcp_pkg::ERR_NONE;
      rsp_valid <= 1'b0;
    end else begin
      phase  <= phase_next;
      hc     <= hc_next;
      tag    <= tag_next;
      len    <= len_next;
      kind   <= kind_next;
      lcount <= lcount_next;
      err    <= err_next;
      if (cmd.emit) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    b      <= b_next;
    tt     <= tt_next;
    hs12   <= hs12_next;
    role   <= role_next;
    hdr    <= hdr_next;
    closed <= closed_next;
    fdone  <= fdone_next;
    if (cmd.emit) rsp <= res_next;
    if (wr_tot_en) ltot[wr_idx] <= wr_tot;
    if (wr_left_en) lleft[wr_idx] <= wr_left;
  end

endmodule

### src/riff_chunk_parser_top.sv
// riff_chunk_parser_top: RIFF chunk parser, sequencer plus datapath.
// Depends on riffcp_pkg, riffcp_ctrl and riffcp_dp.
//
// Usage: the request channel (req_valid, req_stall, req) carries one byte of a
// little-endian RIFF stream per request, with start_of_file set on the first
// byte of a file. Every request yields exactly one result on the response
// channel (rsp_valid, rsp_stall, rsp) giving the byte's role, nesting depth,
// latest header fields, closed level count and sticky error code.
// Timing: a request is taken and then worked on in the next cycle; a plain
// id, size, form or payload byte needs only its decode step. The last header
// byte adds a finish step. Each level closed at the end of a chunk uses the
// single stack port for a check and pop, then a charge of the parent, and a
// final check ends the walk; popping the root needs no charge and ends the
// walk at once. Reaching an odd chunk's pad byte costs a check step.
// The result is registered and valid the cycle after the output register takes it.
// Only one byte is in flight; the next request is taken while the previous
// result still waits in the output register.
// Reset clears the parse state and the stack depth; no clearing pass.
// While rsp_stall is high a finished result waits; the next request is still
// worked, then req_stall stays high until the output register frees.
module riff_chunk_parser_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  riffcp_pkg::req_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output riffcp_pkg::rsp_t  rsp
);

  riffcp_pkg::cmd_t    cmd;
  riffcp_pkg::status_t status;

  riffcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  riffcp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
